/* sv/mdls_pkg.sv */
// Shared types, constants and the control program of the motor drive link sequencer.
// Used by mdls_speed_div.sv, motor_drive_link_sequencer.sv, mdls_action_checker.sv and the testbench.
// No dependencies.
package mdls_pkg;

  // Encoder tick rate used in the speed calculation (counts per second scale)
  localparam int unsigned TICK_RATE = 10000;
  localparam int TICK_W = 30;
  localparam logic [TICK_W-1:0] TICK_RATE_V = TICK_W'(TICK_RATE);

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int ID_W      = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_AZ_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EL_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SK_ID = 2'd2;

  // Control program layout
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] DOWN_START = 6'd0;
  localparam logic [STEP_W-1:0] DOWN_END   = 6'd1;
  localparam logic [STEP_W-1:0] UP_START   = 6'd2;
  localparam logic [STEP_W-1:0] UP_END     = 6'd35;
  localparam logic [STEP_W-1:0] RUN_START  = 6'd36;
  localparam logic [STEP_W-1:0] RUN_END    = 6'd45;

  typedef enum logic [1:0] {
    ACT_SPI  = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2,
    ACT_WAIT = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    G_DOWN = 2'd0,
    G_UP   = 2'd1,
    G_RUN  = 2'd2
  } grp_e;

  typedef enum logic [1:0] {
    TS_NONE = 2'd0,
    TS_AZ   = 2'd1,
    TS_EL   = 2'd2,
    TS_SK   = 2'd3
  } tsel_e;

  // One control word of the program
  typedef struct packed {
    grp_e        grp;
    act_e        act;
    logic [15:0] data;   // SPI word, or wait time in the low 13 bits
    tsel_e       tsel;   // torque word source, overrides data
    logic        gend;   // final step of its group
  } uc_t;

  function automatic uc_t uc_spi(grp_e g, logic [15:0] w);
    uc_t u;
    u = '{grp: g, act: ACT_SPI, data: w, tsel: TS_NONE, gend: 1'b0};
    return u;
  endfunction

  function automatic uc_t uc_wait(grp_e g, logic [12:0] ms);
    uc_t u;
    u = '{grp: g, act: ACT_WAIT, data: {3'd0, ms}, tsel: TS_NONE, gend: 1'b0};
    return u;
  endfunction

  function automatic uc_t uc_act(grp_e g, act_e a);
    uc_t u;
    u = '{grp: g, act: a, data: 16'd0, tsel: TS_NONE, gend: 1'b0};
    return u;
  endfunction

  function automatic uc_t uc_trq(tsel_e t);
    uc_t u;
    u = '{grp: G_RUN, act: ACT_SPI, data: 16'd0, tsel: t, gend: 1'b0};
    return u;
  endfunction

  // Control program: power-down, power-up with init words, then the run loop
  function automatic uc_t uc_rom(logic [STEP_W-1:0] s);
    uc_t u;
    case (s)
      6'd0:  u = uc_act(G_DOWN, ACT_OFF);
      6'd1:  u = uc_wait(G_DOWN, 13'd1000);
      6'd2:  u = uc_act(G_UP, ACT_ON);
      6'd3:  u = uc_wait(G_UP, 13'd5000);
      6'd4:  u = uc_spi(G_UP, 16'h5ba5);
      6'd5:  u = uc_spi(G_UP, 16'hf4ff);
      6'd6:  u = uc_spi(G_UP, 16'hf4ff);
      6'd7:  u = uc_spi(G_UP, 16'ha8ff);
      6'd8:  u = uc_spi(G_UP, 16'ha9fe);
      6'd9:  u = uc_spi(G_UP, 16'ha9fd);
      6'd10: u = uc_spi(G_UP, 16'ha8fc);
      6'd11: u = uc_spi(G_UP, 16'ha9fb);
      6'd12: u = uc_spi(G_UP, 16'ha8fa);
      6'd13: u = uc_spi(G_UP, 16'ha8f9);
      6'd14: u = uc_spi(G_UP, 16'ha9f8);
      6'd15: u = uc_spi(G_UP, 16'ha9f7);
      6'd16: u = uc_spi(G_UP, 16'ha8f6);
      6'd17: u = uc_spi(G_UP, 16'ha8f5);
      6'd18: u = uc_spi(G_UP, 16'ha9f4);
      6'd19: u = uc_spi(G_UP, 16'ha8f3);
      6'd20: u = uc_spi(G_UP, 16'ha9f2);
      6'd21: u = uc_spi(G_UP, 16'ha9f1);
      6'd22: u = uc_wait(G_UP, 13'd100);
      6'd23: u = uc_spi(G_UP, 16'ha45a);
      6'd24: u = uc_spi(G_UP, 16'ha45a);
      6'd25: u = uc_wait(G_UP, 13'd100);
      6'd26: u = uc_spi(G_UP, 16'hfbff);
      6'd27: u = uc_spi(G_UP, 16'hd9f9);
      6'd28: u = uc_spi(G_UP, 16'hd7ef);
      6'd29: u = uc_spi(G_UP, 16'hdcff);
      6'd30: u = uc_spi(G_UP, 16'hdaff);
      6'd31: u = uc_spi(G_UP, 16'hfb77);
      6'd32: u = uc_spi(G_UP, 16'hfa76);
      6'd33: u = uc_spi(G_UP, 16'hfafb);
      6'd34: u = uc_spi(G_UP, 16'hfdff);
      6'd35: u = uc_spi(G_UP, 16'hfcfe);
      6'd36: u = uc_spi(G_RUN, 16'hfeff);
      6'd37: u = uc_spi(G_RUN, 16'hfeff);
      6'd38: u = uc_spi(G_RUN, 16'hfeff);
      6'd39: u = uc_spi(G_RUN, 16'hfeff);
      6'd40: u = uc_spi(G_RUN, 16'hfdff);
      6'd41: u = uc_spi(G_RUN, 16'hfcfe);
      6'd42: u = uc_spi(G_RUN, 16'hfbff);
      6'd43: u = uc_trq(TS_AZ);
      6'd44: u = uc_trq(TS_EL);
      6'd45: u = uc_trq(TS_SK);
      default: u = uc_spi(G_RUN, 16'd0);
    endcase
    u.gend = (s == DOWN_END) || (s == UP_END) || (s >= RUN_END);
    return u;
  endfunction

  // Torque command: 1110, motor id, torque, odd parity in bit 0
  function automatic logic [15:0] torque_word(logic [ID_W-1:0] id, logic [7:0] trq);
    logic [15:0] w;
    w = {4'b1110, id, trq, 1'b0};
    w[0] = ~^w;
    return w;
  endfunction

endpackage

/* sv/mdls_if.sv */
// Valid/ready channel interfaces for the iteration input and the action output.
// Standalone; no package dependency.
interface mdls_in_if;
  logic              valid;
  logic              ready;
  logic              power_up_request;
  logic              power_down_request;
  logic [31:0]       now_ticks;
  logic [7:0]        reply_high_byte;
  logic [7:0]        reply_low_byte;
  logic signed [7:0] torque_azimuth;
  logic signed [7:0] torque_elevation;
  logic signed [7:0] torque_skew;

  modport source (
    output valid, power_up_request, power_down_request, now_ticks,
           reply_high_byte, reply_low_byte, torque_azimuth, torque_elevation,
           torque_skew,
    input  ready
  );
  modport sink (
    input  valid, power_up_request, power_down_request, now_ticks,
           reply_high_byte, reply_low_byte, torque_azimuth, torque_elevation,
           torque_skew,
    output ready
  );
endinterface

interface mdls_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        spi_word;
  logic [12:0]        wait_ms;
  logic               last;
  logic [15:0]        encoder_position;
  logic signed [15:0] encoder_speed;

  modport source (
    output valid, action, spi_word, wait_ms, last, encoder_position, encoder_speed,
    input  ready
  );
  modport sink (
    input  valid, action, spi_word, wait_ms, last, encoder_position, encoder_speed,
    output ready
  );
endinterface

/* sv/mdls_speed_div.sv */
// Encoder speed unit: |dx| * TICK_RATE, saturation check, then a restoring
// divide by the elapsed ticks, one quotient bit per cycle. Uses mdls_pkg.
module mdls_speed_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] dx_i,
  input  logic [31:0]        dt_i,
  output logic               done_o,
  output logic signed [15:0] speed_o
);
  import mdls_pkg::*;

  typedef enum logic [1:0] {
    SP_IDLE = 2'd0,
    SP_MUL  = 2'd1,
    SP_CMP  = 2'd2,
    SP_DIV  = 2'd3
  } sp_state_e;

  sp_state_e          state_q;
  logic               neg_q;
  logic [15:0]        absdx_q;
  logic [31:0]        dt_q;
  logic [47:0]        mag_q;
  logic [47:0]        rem_q;
  logic [47:0]        div_q;
  logic [14:0]        quot_q;
  logic [3:0]         cnt_q;
  logic               done_q;
  logic signed [15:0] speed_q;

  logic [15:0] absdx_d;
  logic        ge;
  logic [14:0] quot_d;

  assign absdx_d = dx_i[15] ? 16'(-dx_i) : dx_i;
  assign ge      = rem_q >= div_q;
  assign quot_d  = {quot_q[13:0], ge};

  // Sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SP_IDLE;
      neg_q   <= 1'b0;
      absdx_q <= '0;
      dt_q    <= '0;
      mag_q   <= '0;
      rem_q   <= '0;
      div_q   <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      speed_q <= '0;
    end else begin
      case (state_q)
        SP_IDLE: begin
          // done pulses for the one cycle spent back in idle
          done_q <= 1'b0;
          if (start_i) begin
            neg_q   <= dx_i[15];
            absdx_q <= absdx_d;
            dt_q    <= dt_i;
            state_q <= SP_MUL;
          end
        end
        SP_MUL: begin
          mag_q   <= 48'(absdx_q) * 48'(TICK_RATE_V);
          state_q <= SP_CMP;
        end
        SP_CMP: begin
          if (absdx_q == 16'd0) begin
            speed_q <= '0;
            done_q  <= 1'b1;
            state_q <= SP_IDLE;
          end else if (mag_q >= {1'b0, dt_q, 15'd0}) begin
            // quotient does not fit (also zero elapsed time): saturate
            speed_q <= neg_q ? 16'sh8000 : 16'sh7fff;
            done_q  <= 1'b1;
            state_q <= SP_IDLE;
          end else begin
            rem_q   <= mag_q;
            div_q   <= {2'd0, dt_q, 14'd0};
            quot_q  <= '0;
            cnt_q   <= 4'd14;
            state_q <= SP_DIV;
          end
        end
        SP_DIV: begin
          if (ge) begin
            rem_q <= rem_q - div_q;
          end
          quot_q <= quot_d;
          div_q  <= div_q >> 1;
          cnt_q  <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            // truncation toward zero: divide magnitudes, then apply sign
            speed_q <= neg_q ? -$signed({1'b0, quot_d}) : $signed({1'b0, quot_d});
            done_q  <= 1'b1;
            state_q <= SP_IDLE;
          end
        end
        default: state_q <= SP_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign speed_o = speed_q;

endmodule

/* sv/motor_drive_link_sequencer.sv */
// Motor drive link sequencer top level: request latches, encoder state,
// program-driven action emitter. Uses mdls_pkg, mdls_if.sv and mdls_speed_div.
// A power-down-only iteration goes straight from accept to the emit phase;
// powered iterations first compute the encoder speed (multiply, range
// check, quotient bits one per cycle, hand-off). Then one action per cycle
// when the output is free; the next iteration is accepted after the last action.
// Reset (async, active low): drive off, latches and encoder state cleared.
module motor_drive_link_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mdls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdls_pkg::ID_W-1:0]      cfg_data_i,
  mdls_in_if.sink                        in_i,
  mdls_out_if.source                     out_o
);
  import mdls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  state_e             state_q;
  logic               powered_q;
  logic               pend_up_q, pend_down_q;
  logic               up_go_q, run_q;
  logic [STEP_W-1:0]  step_q;
  logic [ID_W-1:0]    az_id_q, el_id_q, sk_id_q;
  logic [7:0]         trq_az_q, trq_el_q, trq_sk_q;
  logic [15:0]        position_q, prev_pos_q;
  logic [31:0]        prev_time_q;
  logic signed [15:0] speed_q;

  // output register
  logic               out_valid_q;
  act_e               out_act_q;
  logic [15:0]        out_word_q;
  logic [12:0]        out_wait_q;
  logic               out_last_q;
  logic [15:0]        out_pos_q;
  logic signed [15:0] out_speed_q;

  logic               acc, pu, pd, down_go, after_down, up_go, run;
  logic [15:0]        pos_new;
  logic signed [15:0] dx;
  logic [31:0]        dt;
  logic               spd_start, spd_done;
  logic signed [15:0] spd_speed;
  uc_t                uc;
  logic [15:0]        tword;
  logic               out_free, emit_fire, last_w;
  logic [STEP_W-1:0]  step_first, step_next;

  // Request resolution for the incoming iteration
  assign acc        = in_i.valid && in_i.ready;
  assign pu         = pend_up_q | in_i.power_up_request;
  assign pd         = pend_down_q | in_i.power_down_request;
  assign down_go    = pd & powered_q;
  assign after_down = powered_q & ~down_go;
  assign up_go      = pu & ~after_down;
  assign run        = after_down | up_go;
  assign step_first = down_go ? DOWN_START : (up_go ? UP_START : RUN_START);

  // Encoder deltas
  assign pos_new   = ~{in_i.reply_high_byte, in_i.reply_low_byte};
  assign dx        = $signed(pos_new - prev_pos_q);
  assign dt        = in_i.now_ticks - prev_time_q;
  assign spd_start = acc & run;

  mdls_speed_div u_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (spd_start),
    .dx_i    (dx),
    .dt_i    (dt),
    .done_o  (spd_done),
    .speed_o (spd_speed)
  );

  // Control word decode and torque word selection
  assign uc = uc_rom(step_q);
  always_comb begin
    case (uc.tsel)
      TS_AZ:   tword = torque_word(az_id_q, trq_az_q);
      TS_EL:   tword = torque_word(el_id_q, trq_el_q);
      TS_SK:   tword = torque_word(sk_id_q, trq_sk_q);
      default: tword = uc.data;
    endcase
  end

  // Step sequencing: jump past power-up when it is not served
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_fire = (state_q == ST_EMIT) && out_free;
  assign last_w    = uc.gend &&
                     ((uc.grp == G_RUN) || ((uc.grp == G_DOWN) && !up_go_q && !run_q));
  assign step_next = (uc.gend && (uc.grp == G_DOWN) && !up_go_q) ? RUN_START
                                                                 : step_q + 6'd1;

  // State, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      powered_q   <= 1'b0;
      pend_up_q   <= 1'b0;
      pend_down_q <= 1'b0;
      up_go_q     <= 1'b0;
      run_q       <= 1'b0;
      step_q      <= '0;
      az_id_q     <= 3'd0;
      el_id_q     <= 3'd1;
      sk_id_q     <= 3'd2;
      trq_az_q    <= '0;
      trq_el_q    <= '0;
      trq_sk_q    <= '0;
      position_q  <= '0;
      prev_pos_q  <= '0;
      prev_time_q <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
      out_act_q   <= ACT_SPI;
      out_word_q  <= '0;
      out_wait_q  <= '0;
      out_last_q  <= 1'b0;
      out_pos_q   <= '0;
      out_speed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AZ_ID: az_id_q <= cfg_data_i;
          CFG_EL_ID: el_id_q <= cfg_data_i;
          CFG_SK_ID: sk_id_q <= cfg_data_i;
          default: ;
        endcase
      end

      // beat taken and nothing new loaded behind it
      if (out_valid_q && out_o.ready && !emit_fire) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            pend_up_q   <= pu & ~up_go;
            pend_down_q <= pd & ~down_go;
            powered_q   <= run;
            up_go_q     <= up_go;
            run_q       <= run;
            step_q      <= step_first;
            trq_az_q    <= in_i.torque_azimuth;
            trq_el_q    <= in_i.torque_elevation;
            trq_sk_q    <= in_i.torque_skew;
            if (run) begin
              position_q  <= pos_new;
              prev_pos_q  <= pos_new;
              prev_time_q <= in_i.now_ticks;
              state_q     <= ST_CALC;
            end else if (down_go) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_CALC: begin
          if (spd_done) begin
            speed_q <= spd_speed;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_valid_q <= 1'b1;
            out_act_q   <= uc.act;
            out_word_q  <= (uc.act == ACT_SPI) ? tword : 16'd0;
            out_wait_q  <= (uc.act == ACT_WAIT) ? uc.data[12:0] : 13'd0;
            out_last_q  <= last_w;
            out_pos_q   <= position_q;
            out_speed_q <= speed_q;
            step_q      <= step_next;
            if (last_w) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.action           = out_act_q;
  assign out_o.spi_word         = out_word_q;
  assign out_o.wait_ms          = out_wait_q;
  assign out_o.last             = out_last_q;
  assign out_o.encoder_position = out_pos_q;
  assign out_o.encoder_speed    = out_speed_q;

  // Checks
  a_load_only_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("action loaded outside emit phase");

  a_done_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spd_done |-> state_q == ST_CALC)
    else $error("speed result arrived while not waiting for it");

  a_power_changes_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(powered_q) |-> $past(acc))
    else $error("drive power state changed without an iteration");

  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> step_q <= RUN_END)
    else $error("program step out of range");

  a_last_ends_iteration: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && last_w |=> state_q == ST_IDLE)
    else $error("iteration did not end after its last action");

endmodule

/* sim/mdls_action_checker.sv */
// Action stream checker for the motor drive link sequencer: predicts the actions of each
// accepted iteration and compares every output beat. Depends on mdls_pkg and mdls_if.sv.
module mdls_action_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mdls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdls_pkg::ID_W-1:0]      cfg_data_i,
  mdls_in_if                             in_i,
  mdls_out_if                            out_i,
  output int                             fails_o,
  output int                             pending_o
);
  import mdls_pkg::*;

  localparam logic [16:0] WAIT_FLAG = 17'h10000;
  localparam logic [12:0] POWER_OFF_WAIT_MS = 13'd1000;
  localparam int MAX_REPORTS = 10;

  // Init program after power-on; entries with WAIT_FLAG set are waits in ms
  localparam logic [16:0] INIT_PROGRAM [33] = '{
    WAIT_FLAG | 17'd5000,
    17'h5ba5, 17'hf4ff, 17'hf4ff, 17'ha8ff, 17'ha9fe, 17'ha9fd, 17'ha8fc, 17'ha9fb,
    17'ha8fa, 17'ha8f9, 17'ha9f8, 17'ha9f7, 17'ha8f6, 17'ha8f5, 17'ha9f4, 17'ha8f3,
    17'ha9f2, 17'ha9f1,
    WAIT_FLAG | 17'd100,
    17'ha45a, 17'ha45a,
    WAIT_FLAG | 17'd100,
    17'hfbff, 17'hd9f9, 17'hd7ef, 17'hdcff, 17'hdaff, 17'hfb77, 17'hfa76, 17'hfafb,
    17'hfdff, 17'hfcfe
  };

  // Encoder poll words sent every powered iteration
  localparam logic [15:0] ENCODER_POLL [7] = '{
    16'hfeff, 16'hfeff, 16'hfeff, 16'hfeff, 16'hfdff, 16'hfcfe, 16'hfbff
  };

  typedef struct packed {
    act_e               action;
    logic [15:0]        spi_word;
    logic [12:0]        wait_ms;
    logic               last;
    logic [15:0]        position;
    logic signed [15:0] speed;
  } drive_action_t;

  drive_action_t expected_actions [$];

  // Shadow of the drive state and motor ids
  logic              drive_on, up_latched, down_latched;
  logic [15:0]       enc_pos, last_pos;
  logic signed [15:0] enc_speed;
  logic [31:0]       last_ticks;
  logic [ID_W-1:0]   az_id, el_id, sk_id;

  function automatic drive_action_t plain_action(act_e a, logic [15:0] w, logic [12:0] ms);
    drive_action_t d;
    d = '0;
    d.action = a;
    d.spi_word = (a == ACT_SPI) ? w : 16'd0;
    d.wait_ms = (a == ACT_WAIT) ? ms : 13'd0;
    return d;
  endfunction

  // 1110, motor id, torque byte, then bit 0 forces odd parity
  function automatic logic [15:0] torque_command(logic [ID_W-1:0] id, logic [7:0] trq);
    logic [15:0] w;
    w = {4'b1110, id, trq, 1'b0};
    if ($countones(w) % 2 == 0) w[0] = 1'b1;
    return w;
  endfunction

  // Counts per second from position delta and elapsed ticks, saturated
  function automatic logic signed [15:0] encoder_rate(logic [15:0] pos, logic [15:0] prev,
                                                      logic [31:0] dt);
    logic signed [15:0] dx;
    longint q;
    dx = signed'(16'(pos - prev));
    if (dt == 32'd0) begin
      q = (dx > 0) ? 32767 : ((dx < 0) ? -32768 : 0);
    end else begin
      q = (longint'(dx) * longint'(TICK_RATE)) / longint'({32'd0, dt});
    end
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic string describe(drive_action_t d);
    return $sformatf("act=%0d spi=%h wait=%0d last=%b pos=%h speed=%0d",
                     d.action, d.spi_word, d.wait_ms, d.last, d.position, d.speed);
  endfunction

  task automatic predict_iteration(input logic up, input logic down, input logic [31:0] now,
                                   input logic [15:0] raw, input logic [7:0] az,
                                   input logic [7:0] el, input logic [7:0] sk);
    drive_action_t run [$];
    if (up) up_latched = 1'b1;
    if (down) down_latched = 1'b1;
    // power-down goes first, a pending power-up may follow in the same iteration
    if (down_latched && drive_on) begin
      run.push_back(plain_action(ACT_OFF, 16'd0, 13'd0));
      run.push_back(plain_action(ACT_WAIT, 16'd0, POWER_OFF_WAIT_MS));
      down_latched = 1'b0;
      drive_on = 1'b0;
    end
    if (up_latched && !drive_on) begin
      run.push_back(plain_action(ACT_ON, 16'd0, 13'd0));
      foreach (INIT_PROGRAM[i]) begin
        if (INIT_PROGRAM[i][16]) run.push_back(plain_action(ACT_WAIT, 16'd0,
                                                            INIT_PROGRAM[i][12:0]));
        else run.push_back(plain_action(ACT_SPI, INIT_PROGRAM[i][15:0], 13'd0));
      end
      up_latched = 1'b0;
      drive_on = 1'b1;
    end
    // powered: encoder poll, position/speed update, three torque words
    if (drive_on) begin
      foreach (ENCODER_POLL[i]) run.push_back(plain_action(ACT_SPI, ENCODER_POLL[i], 13'd0));
      enc_pos = ~raw;
      enc_speed = encoder_rate(enc_pos, last_pos, now - last_ticks);
      last_pos = enc_pos;
      last_ticks = now;
      run.push_back(plain_action(ACT_SPI, torque_command(az_id, az), 13'd0));
      run.push_back(plain_action(ACT_SPI, torque_command(el_id, el), 13'd0));
      run.push_back(plain_action(ACT_SPI, torque_command(sk_id, sk), 13'd0));
    end
    foreach (run[i]) begin
      run[i].position = enc_pos;
      run[i].speed = enc_speed;
      run[i].last = (i == run.size() - 1);
      expected_actions.push_back(run[i]);
    end
  endtask

  task automatic check_action();
    drive_action_t got, want;
    got.action = act_e'(out_i.action);
    got.spi_word = out_i.spi_word;
    got.wait_ms = out_i.wait_ms;
    got.last = out_i.last;
    got.position = out_i.encoder_position;
    got.speed = out_i.encoder_speed;
    if (expected_actions.size() == 0) begin
      fails_o++;
      if (fails_o <= MAX_REPORTS) $display("unexpected action beat: %s", describe(got));
    end else begin
      want = expected_actions.pop_front();
      if (got.action !== want.action || got.spi_word !== want.spi_word ||
          got.wait_ms !== want.wait_ms || got.last !== want.last ||
          got.position !== want.position || got.speed !== want.speed) begin
        fails_o++;
        if (fails_o <= MAX_REPORTS) begin
          $display("action beat mismatch: expected %s, got %s", describe(want), describe(got));
        end
      end
    end
  endtask

  // Config writes, then new iterations, then output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_on = 1'b0;
      up_latched = 1'b0;
      down_latched = 1'b0;
      enc_pos = '0;
      last_pos = '0;
      enc_speed = '0;
      last_ticks = '0;
      az_id = 3'd0;
      el_id = 3'd1;
      sk_id = 3'd2;
      expected_actions.delete();
      fails_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AZ_ID: az_id = cfg_data_i;
          CFG_EL_ID: el_id = cfg_data_i;
          CFG_SK_ID: sk_id = cfg_data_i;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        predict_iteration(in_i.power_up_request, in_i.power_down_request, in_i.now_ticks,
                          {in_i.reply_high_byte, in_i.reply_low_byte}, in_i.torque_azimuth,
                          in_i.torque_elevation, in_i.torque_skew);
      end
      if (out_i.valid && out_i.ready) check_action();
      pending_o = expected_actions.size();
    end
  end

endmodule

/* sim/motor_drive_link_sequencer_tb.sv */
// Testbench top for the motor drive link sequencer: clock, reset, iteration and config
// stimulus, output back-pressure and the verdict. Uses mdls_pkg, mdls_if.sv, mdls_action_checker.
module motor_drive_link_sequencer_tb;
  import mdls_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 63;

  typedef enum logic [1:0] {
    RX_OPEN     = 2'd0,
    RX_MOSTLY   = 2'd1,
    RX_SPARSE   = 2'd2,
    RX_PERIODIC = 2'd3
  } rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ID_W-1:0]      cfg_data_i;
  int                   fails;
  int                   pending;
  int                   burst_left = 0;
  int                   quiet_cycles = 0;
  int                   mode_left = 0;
  rx_mode_e             rx_mode = RX_OPEN;
  logic [31:0]          stim_ticks;
  logic [15:0]          stim_raw;

  mdls_in_if  in_ch ();
  mdls_out_if out_ch ();

  motor_drive_link_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  mdls_action_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_i      (out_ch),
    .fails_o    (fails),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Output back-pressure: modes of random length
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 256);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN:   out_ch.ready = 1'b1;
      RX_MOSTLY: out_ch.ready = ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ch.ready = ($urandom_range(0, 3) == 0);
      default:   out_ch.ready = ((mode_left % 7) >= 3);
    endcase
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Drive one iteration; called and returning at a falling edge
  task automatic send_iteration(input logic up, input logic down, input logic [31:0] now,
                                input logic [15:0] raw, input logic [7:0] az,
                                input logic [7:0] el, input logic [7:0] sk);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.power_up_request = up;
    in_ch.power_down_request = down;
    in_ch.now_ticks = now;
    in_ch.reply_high_byte = raw[15:8];
    in_ch.reply_low_byte = raw[7:0];
    in_ch.torque_azimuth = az;
    in_ch.torque_elevation = el;
    in_ch.torque_skew = sk;
    in_ch.valid = 1'b1;
    stim_ticks = now;
    stim_raw = raw;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Mostly plausible motion, sometimes frozen time or arbitrary values
  task automatic random_iteration();
    logic [31:0] now;
    logic [15:0] raw;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) now = stim_ticks + $urandom_range(1, 2000);
    else if (sel == 7) now = stim_ticks;
    else if (sel == 8) now = stim_ticks + $urandom_range(1, 1 << 20);
    else now = $urandom;
    if ($urandom_range(0, 3) != 0) raw = stim_raw + 16'($urandom_range(0, 400)) - 16'd200;
    else raw = 16'($urandom);
    send_iteration($urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0, now, raw,
                   8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Hold off until all actions are out and the block has gone quiet
  task automatic settle();
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_motor_ids(input logic [ID_W-1:0] az, input logic [ID_W-1:0] el,
                               input logic [ID_W-1:0] sk);
    write_reg(CFG_AZ_ID, az);
    write_reg(CFG_EL_ID, el);
    write_reg(CFG_SK_ID, sk);
  endtask

  task automatic random_phase(input int hold_at);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k == hold_at) settle();
      random_iteration();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_AZ_ID;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.power_up_request = 1'b0;
    in_ch.power_down_request = 1'b0;
    in_ch.now_ticks = '0;
    in_ch.reply_high_byte = '0;
    in_ch.reply_low_byte = '0;
    in_ch.torque_azimuth = '0;
    in_ch.torque_elevation = '0;
    in_ch.torque_skew = '0;
    out_ch.ready = 1'b0;
    stim_ticks = '0;
    stim_raw = 16'hffff;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Request handling with reset motor ids
    send_iteration(1'b0, 1'b0, 32'd50, 16'hffff, 8'h00, 8'h00, 8'h00); // idle, no actions
    send_iteration(1'b0, 1'b1, 32'd60, 16'hffff, 8'h00, 8'h00, 8'h00); // down while off stays
    send_iteration(1'b1, 1'b0, 32'd100, 16'hffff, 8'h01, 8'h02, 8'h03);
    send_iteration(1'b0, 1'b0, 32'd150, 16'hffff, 8'h04, 8'h05, 8'h06); // latched down served
    send_iteration(1'b1, 1'b1, 32'd200, 16'hffff, 8'h07, 8'h08, 8'h09); // both while off
    send_iteration(1'b0, 1'b0, 32'd300, 16'hfffe, 8'h10, 8'h20, 8'h30);
    send_iteration(1'b1, 1'b0, 32'd400, 16'hfffe, 8'h11, 8'h22, 8'h33);
    send_iteration(1'b1, 1'b0, 32'd500, 16'hfffc, 8'h12, 8'h24, 8'h36); // up while on stays
    send_iteration(1'b0, 1'b1, 32'd600, 16'hfffc, 8'h13, 8'h26, 8'h39); // down, then up
    send_iteration(1'b1, 1'b1, 32'd700, 16'hfff0, 8'h14, 8'h28, 8'h3c); // both while on
    // Speed corner cases
    send_iteration(1'b0, 1'b0, 32'd700, 16'hff00, 8'h15, 8'h2a, 8'h3f); // no time, moving up
    send_iteration(1'b0, 1'b0, 32'd700, 16'hffff, 8'h16, 8'h2c, 8'h42); // no time, moving down
    send_iteration(1'b0, 1'b0, 32'd700, 16'hffff, 8'h17, 8'h2e, 8'h45); // no time, still
    send_iteration(1'b0, 1'b0, 32'd701, 16'h8000, 8'h7f, 8'h80, 8'h00); // saturates high
    send_iteration(1'b0, 1'b0, 32'd702, 16'h0000, 8'hff, 8'h01, 8'h55); // saturates low
    send_iteration(1'b0, 1'b0, 32'hffffffff, 16'h00ff, 8'haa, 8'hfe, 8'h80);
    send_iteration(1'b0, 1'b0, 32'd0, 16'h0001, 8'h80, 8'h7f, 8'hff); // tick counter wraps
    send_iteration(1'b0, 1'b0, 32'd1000, 16'h5a5a, 8'h5a, 8'ha5, 8'h3c);
    send_iteration(1'b0, 1'b1, 32'd1100, 16'ha5a5, 8'hc3, 8'h3c, 8'h96);
    send_iteration(1'b0, 1'b0, 32'd1200, 16'hffff, 8'h69, 8'h96, 8'h0f);
    send_iteration(1'b1, 1'b0, 32'd1300, 16'hffff, 8'hf0, 8'h0f, 8'he1);

    // Random traffic under several motor id settings
    settle();
    set_motor_ids(3'd7, 3'd7, 3'd7);
    write_reg(CFG_UNUSED, 3'd5);
    random_phase(35);
    settle();
    set_motor_ids(3'd0, 3'd0, 3'd0);
    random_phase(PHASE_ITEMS);
    settle();
    set_motor_ids(3'($urandom), 3'($urandom), 3'($urandom));
    random_phase(PHASE_ITEMS);
    settle();

    if (fails == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* motor_drive_link_sequencer.f */
sv/mdls_pkg.sv
sv/mdls_if.sv
sv/mdls_speed_div.sv
sv/motor_drive_link_sequencer.sv
sim/mdls_action_checker.sv
sim/motor_drive_link_sequencer_tb.sv
